[rtl/fsgs_pkg.sv]
`timescale 1ns / 1ps
package fsgs_pkg;
    localparam int GRID_WIDTH_DEF = 128;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int XW = 7;
    localparam int YW = 6;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef enum logic [1:0] {
        CELL_BARRIER = 2'd0,
        CELL_AIR = 2'd1,
        CELL_SAND = 2'd2,
        CELL_WATER = 2'd3
    } t_cell;

    typedef enum logic [2:0] {
        MODE_RESET = 3'd0,
        MODE_SAND = 3'd1,
        MODE_WATER = 3'd2,
        MODE_BRUSH_BAR = 3'd3,
        MODE_BRUSH_AIR = 3'd4,
        MODE_STEP = 3'd5,
        MODE_READ = 3'd6,
        MODE_NONE = 3'd7
    } t_mode;

    typedef struct packed {
        logic [2:0] mode;
        logic [XW-1:0] cursor_x;
        logic [YW-1:0] cursor_y;
        logic [15:0] random_seed;
    } t_in_word;

    typedef struct packed {
        logic [1:0] cell_type;
        logic cursor_inside;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BRUSH,
        ST_MCLR,
        ST_SRD,
        ST_SCHK,
        ST_NRD,
        ST_NCHK,
        ST_WR_DST,
        ST_WR_SRC,
        ST_RD,
        ST_RDW,
        ST_OUT
    } t_state;

    // controller commands to the datapath
    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_step;
        logic mclr_init;
        logic mclr_step;
        logic brush_init;
        logic brush_step;
        logic scan_init;
        logic scan_step;
        logic src_eval;
        logic nb_init;
        logic nb_read;
        logic nb_next;
        logic wr_dst;
        logic wr_src;
        logic rd_cursor;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mclr_last;
        logic brush_last;
        logic scan_last;
        logic src_active;
        logic nb_air;
        logic nb_last;
        logic out_busy;
    } t_status;
endpackage

[rtl/falling_sand_grid_step.sv]
`timescale 1ns / 1ps
// grid reset: a grid sweep, then a mark sweep
// timestep: a mark sweep, then for each cell a read and a check, for each neighbour probed
// a read and a check, and for each move a write of the destination and then of the source
// one command at a time; the grid memory, with one write and one read port, sets the step rate
// after reset the grid and marks are cleared by sweeps before any word is accepted
module falling_sand_grid_step #(
    parameter int GRID_WIDTH = fsgs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = fsgs_pkg::GRID_HEIGHT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fsgs_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output fsgs_pkg::t_out_word o_word
);
    import fsgs_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_state  state;

    fsgs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_mode(i_word.mode),
        .i_status(status), .o_stall(o_stall), .o_cmd(cmd), .o_state(state)
    );

    fsgs_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_word(i_word),
        .i_out_stall(i_stall), .o_status(status), .o_out_valid(o_valid),
        .o_out_word(o_word)
    );

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state != ST_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_word))) else $error("result lost");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_step, cmd.brush_step, cmd.mclr_step, cmd.wr_dst, cmd.wr_src}))
        else $error("write conflict");
`endif
endmodule

[rtl/fsgs_ram.sv]
`timescale 1ns / 1ps
module fsgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/fsgs_ctrl.sv]
`timescale 1ns / 1ps
module fsgs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0]       i_mode,
    input  fsgs_pkg::t_status i_status,
    output logic             o_stall,
    output fsgs_pkg::t_cmd    o_cmd,
    output fsgs_pkg::t_state  o_state
);
    import fsgs_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode;
    logic   r_boot;

    assign o_state = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_boot  <= 1'b1;
            r_mode  <= MODE_READ;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_valid) begin
                r_mode <= t_mode'(i_mode);
            end
            if (r_state == ST_MCLR && i_status.mclr_last) begin
                r_boot <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (t_mode'(i_mode))
                        MODE_RESET: n_state = ST_CLEAR;
                        MODE_BRUSH_BAR, MODE_BRUSH_AIR: n_state = ST_BRUSH;
                        MODE_STEP: n_state = ST_MCLR;
                        default: n_state = ST_RD;
                    endcase
                end
            end
            ST_CLEAR: if (i_status.clr_last) n_state = ST_MCLR;
            ST_BRUSH: if (i_status.brush_last) n_state = ST_RD;
            ST_MCLR: begin
                if (i_status.mclr_last) begin
                    if (r_boot) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = (r_mode == MODE_RESET) ? ST_RD : ST_SRD;
                    end
                end
            end
            ST_SRD: n_state = ST_SCHK;
            ST_SCHK: begin
                if (i_status.src_active) begin
                    n_state = ST_NRD;
                end else if (i_status.scan_last) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_NRD: n_state = ST_NCHK;
            ST_NCHK: begin
                if (i_status.nb_air) begin
                    n_state = ST_WR_DST;
                end else if (!i_status.nb_last) begin
                    n_state = ST_NRD;
                end else if (i_status.scan_last) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_WR_DST: n_state = ST_WR_SRC;
            ST_WR_SRC: n_state = i_status.scan_last ? ST_RD : ST_SRD;
            ST_RD: n_state = ST_RDW;
            ST_RDW: n_state = ST_OUT;
            ST_OUT: if (!i_status.out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr_init = 1'b1;
                    o_cmd.mclr_init = 1'b1;
                    o_cmd.brush_init = 1'b1;
                    o_cmd.scan_init = 1'b1;
                end
            end
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_BRUSH: o_cmd.brush_step = 1'b1;
            ST_MCLR: o_cmd.mclr_step = 1'b1;
            ST_SRD: ;
            ST_SCHK: begin
                o_cmd.src_eval = 1'b1;
                o_cmd.nb_init = 1'b1;
                o_cmd.scan_step = !i_status.src_active;
            end
            ST_NRD: o_cmd.nb_read = 1'b1;
            ST_NCHK: begin
                o_cmd.nb_next = !i_status.nb_air;
                o_cmd.scan_step = !i_status.nb_air && i_status.nb_last;
            end
            ST_WR_DST: o_cmd.wr_dst = 1'b1;
            ST_WR_SRC: begin
                o_cmd.wr_src = 1'b1;
                o_cmd.scan_step = 1'b1;
            end
            ST_RD, ST_RDW: o_cmd.rd_cursor = 1'b1;
            ST_OUT: begin
                o_cmd.rd_cursor = 1'b1;
                o_cmd.out_load = !i_status.out_busy;
            end
            default: ;
        endcase
    end
endmodule

[rtl/fsgs_dp.sv]
`timescale 1ns / 1ps
module fsgs_dp #(
    parameter int GRID_WIDTH = fsgs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = fsgs_pkg::GRID_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsgs_pkg::t_cmd     i_cmd,
    input  fsgs_pkg::t_in_word i_word,
    input  logic               i_out_stall,
    output fsgs_pkg::t_status  o_status,
    output logic               o_out_valid,
    output fsgs_pkg::t_out_word o_out_word
);
    import fsgs_pkg::*;

    localparam int GXW = $clog2(GRID_WIDTH);
    localparam int GYW = $clog2(GRID_HEIGHT);
    localparam int AW = GXW + GYW;
    localparam int DEPTH = 1 << AW;
    // signed coordinate width with room for -1 and +1
    localparam int CW = ((GXW > GYW) ? GXW : GYW) + 2;

    t_in_word r_word;
    logic [AW-1:0] r_clr;
    logic signed [CW-1:0] r_sx, r_sy;
    logic [3:0] r_bi;
    logic [2:0] r_ni;
    logic [15:0] r_lfsr;
    logic r_first;
    t_cell r_src;
    logic r_nb_in;
    logic r_out_valid;
    t_out_word r_out;

    logic g_we;
    logic [AW-1:0] g_waddr, g_raddr;
    logic [1:0] g_wdata, g_rdata;
    logic m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic m_wdata, m_rdata;

    fsgs_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata)
    );
    fsgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    function automatic logic inside_xy(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y);
        return x > 0 && y > 0 && x < CW'(GRID_WIDTH - 1) && y < CW'(GRID_HEIGHT - 1);
    endfunction
    function automatic logic in_grid(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y);
        return x >= 0 && y >= 0 && x < CW'(GRID_WIDTH) && y < CW'(GRID_HEIGHT);
    endfunction
    function automatic logic [AW-1:0] addr(input logic signed [CW-1:0] x,
                                           input logic signed [CW-1:0] y);
        return {y[GYW-1:0], x[GXW-1:0]};
    endfunction

    logic signed [CW-1:0] cx, cy, bx, by, nx, ny, dx, dy, clx, cly;
    logic cur_in, nb_in;
    logic [1:0] bxo, byo;

    // brush offsets, column then row, each 0..2
    always_comb begin
        unique case (r_bi)
            4'd0: {bxo, byo} = 4'b0000;
            4'd1: {bxo, byo} = 4'b0001;
            4'd2: {bxo, byo} = 4'b0010;
            4'd3: {bxo, byo} = 4'b0100;
            4'd4: {bxo, byo} = 4'b0101;
            4'd5: {bxo, byo} = 4'b0110;
            4'd6: {bxo, byo} = 4'b1000;
            4'd7: {bxo, byo} = 4'b1001;
            default: {bxo, byo} = 4'b1010;
        endcase
    end

    assign cx = CW'($signed({1'b0, r_word.cursor_x}));
    assign cy = CW'($signed({1'b0, r_word.cursor_y}));
    assign cur_in = inside_xy(cx, cy);
    assign bx = cx + CW'($signed({1'b0, bxo})) - CW'(1);
    assign by = cy + CW'($signed({1'b0, byo})) - CW'(1);
    assign clx = CW'($signed({1'b0, r_clr[GXW-1:0]}));
    assign cly = CW'($signed({1'b0, r_clr[AW-1:GXW]}));

    // neighbour order: down, first diag, second diag, first side, second side
    always_comb begin
        dy = CW'(1);
        dx = '0;
        unique case (r_ni)
            3'd0: dx = '0;
            3'd1: dx = r_first ? CW'(1) : -CW'(1);
            3'd2: dx = r_first ? -CW'(1) : CW'(1);
            3'd3: begin dx = r_first ? CW'(1) : -CW'(1); dy = '0; end
            default: begin dx = r_first ? -CW'(1) : CW'(1); dy = '0; end
        endcase
    end
    assign nx = r_sx + dx;
    assign ny = r_sy + dy;
    assign nb_in = in_grid(nx, ny);

    always_comb begin
        g_we = 1'b0;
        g_waddr = addr(nx, ny);
        g_wdata = r_src;
        g_raddr = addr(r_sx, r_sy);
        if (i_cmd.clr_step) begin
            g_we = 1'b1;
            g_waddr = r_clr;
            g_wdata = inside_xy(clx, cly) ? CELL_AIR : CELL_BARRIER;
        end else if (i_cmd.brush_step) begin
            g_we = cur_in && inside_xy(bx, by);
            g_waddr = addr(bx, by);
            g_wdata = (t_mode'(r_word.mode) == MODE_BRUSH_BAR) ? CELL_BARRIER : CELL_AIR;
        end else if (i_cmd.wr_dst) begin
            g_we = 1'b1;
        end else if (i_cmd.wr_src) begin
            g_we = 1'b1;
            g_waddr = addr(r_sx, r_sy);
            g_wdata = CELL_AIR;
        end
        if (i_cmd.nb_read) g_raddr = addr(nx, ny);
        if (i_cmd.rd_cursor) g_raddr = addr(cx, cy);
        if (i_cmd.load && (t_mode'(i_word.mode) == MODE_SAND ||
                           t_mode'(i_word.mode) == MODE_WATER)) begin
            g_we = inside_xy(CW'($signed({1'b0, i_word.cursor_x})),
                             CW'($signed({1'b0, i_word.cursor_y})));
            g_waddr = {i_word.cursor_y[GYW-1:0], i_word.cursor_x[GXW-1:0]};
            g_wdata = (t_mode'(i_word.mode) == MODE_SAND) ? CELL_SAND : CELL_WATER;
        end
    end

    assign m_we = i_cmd.mclr_step || i_cmd.wr_dst;
    assign m_waddr = i_cmd.mclr_step ? r_clr : addr(nx, ny);
    assign m_wdata = !i_cmd.mclr_step;
    assign m_raddr = addr(r_sx, r_sy);

    logic src_act;
    assign src_act = !m_rdata && (g_rdata == CELL_SAND || g_rdata == CELL_WATER);

    assign o_status.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_status.mclr_last = (r_clr == AW'(DEPTH - 1));
    assign o_status.brush_last = (r_bi == 4'd8);
    assign o_status.scan_last = (r_sx == CW'(GRID_WIDTH - 1)) &&
                                (r_sy == CW'(GRID_HEIGHT - 1));
    assign o_status.src_active = src_act;
    assign o_status.nb_air = r_nb_in && (g_rdata == CELL_AIR);
    assign o_status.nb_last = (r_ni == ((r_src == CELL_WATER) ? 3'd4 : 3'd2));
    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= 16'd1;
            r_out_valid <= 1'b0;
            r_clr <= '0;
        end else begin
            r_out_valid <= i_cmd.out_load || (r_out_valid && i_out_stall);
            if (i_cmd.clr_init || i_cmd.mclr_init) r_clr <= '0;
            else if (i_cmd.clr_step || i_cmd.mclr_step) r_clr <= r_clr + AW'(1);
            if (i_cmd.load && t_mode'(i_word.mode) == MODE_STEP) begin
                r_lfsr <= (i_word.random_seed == '0) ? 16'd1 : i_word.random_seed;
            end else if (i_cmd.src_eval && src_act) begin
                r_lfsr <= (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 16'd0);
            end
        end
        if (i_cmd.load) r_word <= i_word;
        if (i_cmd.brush_init) r_bi <= '0;
        else if (i_cmd.brush_step) r_bi <= r_bi + 4'd1;
        if (i_cmd.scan_init) begin
            r_sx <= '0;
            r_sy <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_sy == CW'(GRID_HEIGHT - 1)) begin
                r_sy <= '0;
                r_sx <= r_sx + CW'(1);
            end else begin
                r_sy <= r_sy + CW'(1);
            end
        end
        if (i_cmd.src_eval) begin
            r_src <= t_cell'(g_rdata);
            r_first <= r_lfsr[0];
        end
        if (i_cmd.nb_init) r_ni <= '0;
        else if (i_cmd.nb_next) r_ni <= r_ni + 3'd1;
        if (i_cmd.nb_read) r_nb_in <= nb_in;
        if (i_cmd.out_load) begin
            r_out.cursor_inside <= cur_in;
            r_out.cell_type <= (cx < CW'(GRID_WIDTH) && cy < CW'(GRID_HEIGHT)) ?
                               g_rdata : CELL_BARRIER;
        end
    end
endmodule
